// File: rtl/kcne_pkg.sv
// ----------------------------------------------------------------------------
// Key change note events: shared package
// Key vector sizing, register codes and the types passed between the front,
// the queue and the back of the block.
// ----------------------------------------------------------------------------
package kcne_pkg;

	localparam int KEY_COUNT = 37;
	localparam int LEVEL_W   = 37;
	localparam int IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int NOTE_W    = 7;
	localparam int VEL_W     = 7;
	localparam int CHAN_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BASE_NOTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL   = 2'd2;

	localparam logic [NOTE_W-1:0] BASE_NOTE_RST = 7'd41;
	localparam logic [VEL_W-1:0]  VELOCITY_RST  = 7'd0;
	localparam logic [CHAN_W-1:0] CHANNEL_RST   = 5'd1;

	typedef logic [KEY_COUNT-1:0] key_vec_t;

	// One scan's worth of work for the back: which keys changed and which
	// of them are now pressed.
	typedef struct packed {
		key_vec_t changed;
		key_vec_t pressed;
	} scan_job_t;

	typedef struct packed {
		logic      push;
		scan_job_t job;
	} job_push_t;

	typedef struct packed {
		logic      avail;
		scan_job_t job;
	} job_head_t;

endpackage

// File: rtl/kcne_front.sv
// ----------------------------------------------------------------------------
// Key change note events: front
// Accepts scans, keeps the previous pressed set and queues change jobs.
// ----------------------------------------------------------------------------
module kcne_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kcne_pkg::LEVEL_W-1:0]  key_levels,
	input  logic                          queue_full,
	output kcne_pkg::job_push_t           push
);

	kcne_pkg::key_vec_t prev_pressed_q;
	kcne_pkg::key_vec_t pressed;
	kcne_pkg::key_vec_t changed;
	logic               accept;

	// Missing level bits read as zero, so extra keys count as pressed.
	assign pressed  = ~kcne_pkg::key_vec_t'(key_levels);
	assign changed  = pressed ^ prev_pressed_q;
	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	always_comb begin
		push.push        = accept && (changed != '0);
		push.job.changed = changed;
		push.job.pressed = pressed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pressed_q <= '0;
		end else if (accept) begin
			prev_pressed_q <= pressed;
		end
	end

endmodule

// File: rtl/kcne_fifo.sv
// ----------------------------------------------------------------------------
// Key change note events: job queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module kcne_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kcne_pkg::job_push_t  push,
	input  logic                 pop,
	output logic                 full,
	output kcne_pkg::job_head_t  head
);

	kcne_pkg::scan_job_t              entry_q [kcne_pkg::QUEUE_DEPTH];
	logic [kcne_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [kcne_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [kcne_pkg::QCNT_W-1:0]      count_q;
	logic                             do_pop;

	assign full       = (count_q == kcne_pkg::QCNT_W'(kcne_pkg::QUEUE_DEPTH));
	assign head.avail = (count_q != '0);
	assign head.job   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head.avail;

	always_ff @(posedge clk) begin
		if (push.push) begin
			entry_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= (wr_ptr_q == kcne_pkg::QPTR_W'(kcne_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == kcne_pkg::QPTR_W'(kcne_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push.push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/kcne_back.sv
// ----------------------------------------------------------------------------
// Key change note events: back
// Walks a job's keys one per cycle (out_stall holds a change); one event each.
// ----------------------------------------------------------------------------
module kcne_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kcne_pkg::job_head_t            head,
	output logic                           pop,
	input  logic [kcne_pkg::NOTE_W-1:0]    base_note,
	input  logic [kcne_pkg::VEL_W-1:0]     note_velocity,
	input  logic [kcne_pkg::CHAN_W-1:0]    midi_channel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [kcne_pkg::NOTE_W-1:0]    note,
	output logic                           note_on,
	output logic [kcne_pkg::VEL_W-1:0]     velocity_out,
	output logic [kcne_pkg::CHAN_W-1:0]    channel_out,
	output logic                           last
);

	logic                         busy_q;
	kcne_pkg::key_vec_t           work_q;
	kcne_pkg::key_vec_t           press_q;
	logic [kcne_pkg::IDX_W-1:0]   idx_q;
	logic                         out_valid_q;
	logic [kcne_pkg::NOTE_W-1:0]  note_q;
	logic                         note_on_q;
	logic [kcne_pkg::VEL_W-1:0]   vel_q;
	logic [kcne_pkg::CHAN_W-1:0]  chan_q;
	logic                         last_q;

	kcne_pkg::key_vec_t           rest;
	logic                         out_free;
	logic                         step;
	logic                         emit;

	assign rest     = work_q >> 1;
	assign out_free = !out_valid_q || !out_stall;
	// A key without a change never waits on the output.
	assign step     = busy_q && (!work_q[0] || out_free);
	assign emit     = step && work_q[0];
	assign pop      = !busy_q && head.avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (step) begin
				if (rest == '0) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q  <= head.job.changed;
			press_q <= head.job.pressed;
		end else if (step) begin
			work_q  <= rest;
			press_q <= press_q >> 1;
		end
		if (emit) begin
			note_q    <= kcne_pkg::NOTE_W'(base_note + kcne_pkg::NOTE_W'(idx_q));
			note_on_q <= press_q[0];
			vel_q     <= note_velocity;
			chan_q    <= midi_channel;
			last_q    <= (rest == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign note         = note_q;
	assign note_on      = note_on_q;
	assign velocity_out = vel_q;
	assign channel_out  = chan_q;
	assign last         = last_q;

endmodule

// File: rtl/key_change_note_events_top.sv
// ----------------------------------------------------------------------------
// Key change note events: top level
// Turns keyboard scans into note on and note off event words.
// ----------------------------------------------------------------------------
// Each input word is one scan of all key levels, active low. The block
// compares the pressed set with the one from the previous scan and, for every
// key that changed, sends one event word in ascending key order: the note
// (base note plus key index, modulo 128), the on or off flag, the configured
// velocity and channel, and last set on the final event of the scan. A scan
// with no change produces no word. The front takes a scan while the queue is
// not full and queues a job if any key changed (two jobs deep). The back takes
// a job from the queue, then steps through the keys up to the highest changed
// key. With the back idle, the first event word of a scan passes the queue
// entry, the work registers and the output registers. Event words leave one
// per cycle while consecutive keys change and the output is not stalled.
// Configuration registers are written through the cfg port, which is always
// ready; write them only while the block is idle.
// ----------------------------------------------------------------------------
module key_change_note_events_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [kcne_pkg::LEVEL_W-1:0]      key_levels,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [kcne_pkg::NOTE_W-1:0]       note,
	output logic                              note_on,
	output logic [kcne_pkg::VEL_W-1:0]        velocity_out,
	output logic [kcne_pkg::CHAN_W-1:0]       channel_out,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kcne_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kcne_pkg::CFG_DAT_W-1:0]    cfg_data
);

	logic [kcne_pkg::NOTE_W-1:0] base_note_q;
	logic [kcne_pkg::VEL_W-1:0]  velocity_q;
	logic [kcne_pkg::CHAN_W-1:0] channel_q;

	kcne_pkg::job_push_t push;
	kcne_pkg::job_head_t head;
	logic                queue_full;
	logic                pop;

	// Registers take the low bits of the data word; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_note_q <= kcne_pkg::BASE_NOTE_RST;
			velocity_q  <= kcne_pkg::VELOCITY_RST;
			channel_q   <= kcne_pkg::CHANNEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kcne_pkg::REG_BASE_NOTE: base_note_q <= kcne_pkg::NOTE_W'(cfg_data);
				kcne_pkg::REG_VELOCITY:  velocity_q  <= kcne_pkg::VEL_W'(cfg_data);
				kcne_pkg::REG_CHANNEL:   channel_q   <= kcne_pkg::CHAN_W'(cfg_data);
				default: ;
			endcase
		end
	end

	kcne_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_levels (key_levels),
		.queue_full (queue_full),
		.push       (push)
	);

	kcne_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (queue_full),
		.head   (head)
	);

	kcne_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.base_note     (base_note_q),
		.note_velocity (velocity_q),
		.midi_channel  (channel_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.note          (note),
		.note_on       (note_on),
		.velocity_out  (velocity_out),
		.channel_out   (channel_out),
		.last          (last)
	);

endmodule
